// ===== hw/rtl/skm_pkg.sv =====
// Shared constants and types for the sorted key map engine.
package skm_pkg;

    localparam int Depth      = 256;
    localparam int PosBits    = 8;
    localparam int CountBits  = 9;
    localparam int KeyBits    = 32;
    localparam int ValueBits  = 32;
    localparam int ModeBits   = 3;

    localparam logic [ModeBits-1:0] MODE_INSERT = 3'd0;
    localparam logic [ModeBits-1:0] MODE_ERASE  = 3'd1;
    localparam logic [ModeBits-1:0] MODE_FIND   = 3'd2;
    localparam logic [ModeBits-1:0] MODE_DELETE = 3'd3;
    localparam logic [ModeBits-1:0] MODE_READ   = 3'd4;
    localparam logic [ModeBits-1:0] MODE_CLEAR  = 3'd5;

    typedef logic [PosBits-1:0]   t_pos;
    typedef logic [CountBits-1:0] t_count;
    typedef logic [KeyBits-1:0]   t_key;
    typedef logic [ValueBits-1:0] t_value;

endpackage

// ===== hw/rtl/sorted_key_map_engine.sv =====
// Sorted key map engine: order table, slot stores and free-slot stack in memories.
// Sequence: read/delete at position skip the search; find/insert/erase first run a binary search
//   (9 steps at 256 entries); insert/erase/delete then shift up to 255 order-table entries.
// Throughput: one transaction at a time, next accepted the cycle after the result is taken
//   (after a clear, also not before the free-stack pass ends); order-table shift: one entry per cycle.
// Reset: synchronous, active low; count cleared, then a free-stack identity pass over all 256 entries.
module sorted_key_map_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [skm_pkg::ModeBits-1:0] i_mode,
    input  skm_pkg::t_key               i_key,
    input  skm_pkg::t_value             i_value,
    input  skm_pkg::t_pos               i_position,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_ok,
    output skm_pkg::t_pos               o_where,
    output skm_pkg::t_key               o_found_key,
    output skm_pkg::t_value             o_found_value,
    output skm_pkg::t_count             o_entry_count
);

    // state codes
    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_SKEY   = 4'd3;
    localparam logic [3:0] S_DEC    = 4'd4;
    localparam logic [3:0] S_RSLOT  = 4'd5;
    localparam logic [3:0] S_RDATA  = 4'd6;
    localparam logic [3:0] S_FETCH  = 4'd7;
    localparam logic [3:0] S_INSW   = 4'd8;
    localparam logic [3:0] S_SHUP   = 4'd9;
    localparam logic [3:0] S_SHDN   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;
    localparam logic [3:0] S_RMSL   = 4'd13;

    // memories
    skm_pkg::t_key   key_mem   [skm_pkg::Depth];
    skm_pkg::t_value val_mem   [skm_pkg::Depth];
    skm_pkg::t_pos   ord_mem   [skm_pkg::Depth];
    skm_pkg::t_pos   free_mem  [skm_pkg::Depth];

    logic [3:0]        r_state;
    skm_pkg::t_count   r_count;
    logic [skm_pkg::ModeBits-1:0] r_mode;
    skm_pkg::t_key     r_key;
    skm_pkg::t_value   r_value;
    skm_pkg::t_count   r_lo, r_hi, r_idx;
    skm_pkg::t_pos     r_init;
    skm_pkg::t_pos     r_slot;
    logic              r_ok;
    skm_pkg::t_pos     r_where;
    skm_pkg::t_key     r_fk;
    skm_pkg::t_value   r_fv;
    logic              r_ovalid;

    // memory ports
    logic            ord_we;
    skm_pkg::t_pos   ord_wa, ord_ra, ord_wd, r_ord_q;
    logic            kv_we;
    skm_pkg::t_pos   kv_wa, kv_ra;
    skm_pkg::t_key   r_key_q;
    skm_pkg::t_value r_val_q;
    logic            fr_we;
    skm_pkg::t_pos   fr_wa, fr_wd, fr_ra, r_fr_q;

    always_ff @(posedge i_clk) begin
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        r_ord_q <= ord_mem[ord_ra];
        if (kv_we) begin
            key_mem[kv_wa] <= r_key;
            val_mem[kv_wa] <= r_value;
        end
        r_key_q <= key_mem[kv_ra];
        r_val_q <= val_mem[kv_ra];
        if (fr_we) free_mem[fr_wa] <= fr_wd;
        r_fr_q <= free_mem[fr_ra];
    end

    skm_pkg::t_count mid;
    logic            accept;
    logic            out_take;
    logic            found;
    skm_pkg::t_pos   cnt_pos;

    assign accept   = i_valid && !o_stall;
    assign out_take = r_ovalid && !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign found    = (r_lo < r_count) && (r_key_q == r_key);
    assign cnt_pos  = r_count[skm_pkg::PosBits-1:0];

    // memory addressing
    always_comb begin
        ord_we = 1'b0; ord_wa = r_idx[skm_pkg::PosBits-1:0]; ord_wd = r_ord_q;
        ord_ra = mid[skm_pkg::PosBits-1:0];
        kv_we  = 1'b0; kv_wa = r_slot; kv_ra = r_ord_q;
        fr_we  = 1'b0; fr_wa = r_init; fr_wd = r_init;
        fr_ra  = cnt_pos;
        unique case (r_state)
            S_INIT: fr_we = 1'b1;
            S_RSLOT: ord_ra = r_lo[skm_pkg::PosBits-1:0];
            // read runs one entry ahead of the write once the shift is under way
            S_SHUP: begin
                ord_ra = r_idx[skm_pkg::PosBits-1:0] - (r_slot[0] ? 8'd2 : 8'd1);
                ord_wa = r_idx[skm_pkg::PosBits-1:0];
            end
            S_SHDN: begin
                ord_ra = r_idx[skm_pkg::PosBits-1:0] + (r_slot[0] ? 8'd2 : 8'd1);
                ord_wa = r_idx[skm_pkg::PosBits-1:0];
            end
            S_INSW: begin
                ord_we = 1'b1; ord_wa = r_lo[skm_pkg::PosBits-1:0]; ord_wd = r_fr_q;
                kv_we  = 1'b1; kv_wa = r_fr_q;
            end
            S_RMSL: begin
                fr_we = 1'b1; fr_wa = cnt_pos - 8'd1; fr_wd = r_slot;
            end
            default: ;
        endcase
        // write the value read last cycle during shifts
        if (r_state == S_SHUP || r_state == S_SHDN) ord_we = r_slot[0];
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_count  <= '0;
            r_init   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_take) r_ovalid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_init <= r_init + 8'd1;
                    if (r_init == 8'(skm_pkg::Depth - 1)) begin
                        r_state <= (r_ovalid && !out_take) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: if (accept) begin
                    r_mode <= i_mode; r_key <= i_key; r_value <= i_value;
                    r_ok <= 1'b0; r_where <= '0; r_fk <= '0; r_fv <= '0;
                    r_lo <= '0; r_hi <= r_count;
                    unique case (i_mode)
                        skm_pkg::MODE_INSERT, skm_pkg::MODE_ERASE, skm_pkg::MODE_FIND:
                            r_state <= S_SRCH;
                        skm_pkg::MODE_DELETE, skm_pkg::MODE_READ: begin
                            if ({1'b0, i_position} < r_count) begin
                                r_lo <= {1'b0, i_position};
                                r_state <= S_RSLOT;
                            end else r_state <= S_DONE;
                        end
                        skm_pkg::MODE_CLEAR: begin
                            r_ok <= 1'b1; r_count <= '0; r_init <= '0;
                            r_ovalid <= 1'b1; r_state <= S_INIT;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                // binary search: ord read issued, then key read
                S_SRCH: begin
                    if (r_lo < r_hi) r_state <= S_SKEY;
                    else begin
                        r_state <= S_RSLOT;
                    end
                end
                S_SKEY: r_state <= S_DEC;
                S_DEC: begin
                    if (r_key > r_key_q) r_lo <= mid + 9'd1;
                    else r_hi <= mid;
                    r_state <= S_SRCH;
                end
                S_RSLOT: r_state <= S_RDATA;  // order entry at r_lo being read
                S_RDATA: begin
                    r_slot <= r_ord_q;
                    r_state <= S_FETCH;        // key/value read issued
                end
                S_FETCH: begin
                    unique case (r_mode)
                        skm_pkg::MODE_INSERT: begin
                            if (r_count == 9'(skm_pkg::Depth) || found) r_state <= S_DONE;
                            else begin
                                r_idx <= r_count; r_slot <= 8'd0;
                                r_state <= S_SHUP;
                            end
                        end
                        skm_pkg::MODE_FIND: begin
                            if (found) begin
                                r_ok <= 1'b1; r_where <= r_lo[skm_pkg::PosBits-1:0];
                                r_fk <= r_key_q; r_fv <= r_val_q;
                            end
                            r_state <= S_DONE;
                        end
                        skm_pkg::MODE_READ: begin
                            r_ok <= 1'b1; r_where <= r_lo[skm_pkg::PosBits-1:0];
                            r_fk <= r_key_q; r_fv <= r_val_q;
                            r_state <= S_DONE;
                        end
                        default: begin
                            if (r_mode == skm_pkg::MODE_ERASE && !found) r_state <= S_DONE;
                            else begin
                                r_ok <= 1'b1; r_where <= r_lo[skm_pkg::PosBits-1:0];
                                r_idx <= r_lo; r_state <= S_RMSL;
                            end
                        end
                    endcase
                end
                // r_slot holds the removed slot; it goes back on the free stack
                S_RMSL: begin
                    r_count <= r_count - 9'd1;
                    r_slot <= 8'd0;
                    r_state <= S_SHDN;
                end
                // shift down: read i+1, write i next cycle
                S_SHDN: begin
                    if (r_slot[0]) r_idx <= r_idx + 9'd1;
                    if (r_idx + (r_slot[0] ? 9'd1 : 9'd0) >= r_count) r_state <= S_DONE;
                    else r_slot <= 8'd1;
                    if (r_slot[0] && r_idx + 9'd1 >= r_count) r_state <= S_DONE;
                end
                // shift up: read i-1, write i next cycle
                S_SHUP: begin
                    if (r_slot[0]) r_idx <= r_idx - 9'd1;
                    if ((r_slot[0] ? r_idx - 9'd1 : r_idx) <= r_lo) r_state <= S_INSW;
                    else r_slot <= 8'd1;
                end
                S_INSW: begin
                    r_ok <= 1'b1; r_where <= r_lo[skm_pkg::PosBits-1:0];
                    r_count <= r_count + 9'd1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (out_take) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_ok          = r_ok;
    assign o_where       = r_where;
    assign o_found_key   = r_fk;
    assign o_found_value = r_fv;
    assign o_entry_count = r_count;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 9'(skm_pkg::Depth)) else $error("count beyond depth");
    a_fail_where: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_where == '0)) else $error("where set on failure");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> r_ovalid) else $error("result dropped");
`endif

endmodule

// ===== tb/sorted_key_map_engine_tb.sv =====
// Self-checking testbench for the sorted key map engine: random and directed map operations.
`timescale 1ns / 100ps

module sorted_key_map_engine_tb;

    typedef struct packed {
        logic [skm_pkg::ModeBits-1:0] mode;
        skm_pkg::t_key                key;
        skm_pkg::t_value              value;
        skm_pkg::t_pos                position;
    } t_request;

    typedef struct packed {
        logic            ok;
        skm_pkg::t_pos   where;
        skm_pkg::t_key   found_key;
        skm_pkg::t_value found_value;
        skm_pkg::t_count entry_count;
    } t_answer;

    localparam int MaxCycles = 3_000_000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [skm_pkg::ModeBits-1:0] i_mode;
    skm_pkg::t_key                i_key;
    skm_pkg::t_value              i_value;
    skm_pkg::t_pos                i_position;
    logic                         o_valid;
    logic                         i_stall;
    logic                         o_ok;
    skm_pkg::t_pos                o_where;
    skm_pkg::t_key                o_found_key;
    skm_pkg::t_value              o_found_value;
    skm_pkg::t_count              o_entry_count;

    sorted_key_map_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ok          (o_ok),
        .o_where       (o_where),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count)
    );

    // Predictor state: live entries kept sorted by key
    skm_pkg::t_key   map_keys[$];
    skm_pkg::t_value map_values[$];

    t_request pending_requests[$];
    t_answer  expected_answers[$];
    int       mismatch_count;
    int       cycle_count = 0;
    bit       stimulus_done;
    int       long_hold = 0;

    // Clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Cycle counter
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Reports one mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Lowest position whose key is not below k
    function automatic int lower_position(input skm_pkg::t_key k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = map_keys.size();
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (k > map_keys[mid]) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // Applies one operation to the map and returns the answer it produces
    function automatic t_answer apply_map_op(input t_request r);
        t_answer a;
        int      p;
        a = '0;
        p = lower_position(r.key);
        case (r.mode)
            skm_pkg::MODE_INSERT: begin
                if (map_keys.size() < skm_pkg::Depth &&
                    !(p < map_keys.size() && map_keys[p] == r.key)) begin
                    map_keys.insert(p, r.key);
                    map_values.insert(p, r.value);
                    a.ok = 1'b1;
                    a.where = skm_pkg::t_pos'(p);
                end
            end
            skm_pkg::MODE_ERASE: begin
                if (p < map_keys.size() && map_keys[p] == r.key) begin
                    map_keys.delete(p);
                    map_values.delete(p);
                    a.ok = 1'b1;
                    a.where = skm_pkg::t_pos'(p);
                end
            end
            skm_pkg::MODE_FIND: begin
                if (p < map_keys.size() && map_keys[p] == r.key) begin
                    a.ok = 1'b1;
                    a.where = skm_pkg::t_pos'(p);
                    a.found_key = map_keys[p];
                    a.found_value = map_values[p];
                end
            end
            skm_pkg::MODE_DELETE: begin
                if (r.position < map_keys.size()) begin
                    map_keys.delete(r.position);
                    map_values.delete(r.position);
                    a.ok = 1'b1;
                    a.where = r.position;
                end
            end
            skm_pkg::MODE_READ: begin
                if (r.position < map_keys.size()) begin
                    a.ok = 1'b1;
                    a.where = r.position;
                    a.found_key = map_keys[r.position];
                    a.found_value = map_values[r.position];
                end
            end
            skm_pkg::MODE_CLEAR: begin
                map_keys.delete();
                map_values.delete();
                a.ok = 1'b1;
            end
            default: ;
        endcase
        a.entry_count = skm_pkg::t_count'(map_keys.size());
        return a;
    endfunction

    function automatic t_request make_request(input logic [skm_pkg::ModeBits-1:0] m,
                                              input skm_pkg::t_key k,
                                              input skm_pkg::t_value v,
                                              input skm_pkg::t_pos p);
        t_request r;
        r.mode = m;
        r.key = k;
        r.value = v;
        r.position = p;
        return r;
    endfunction

    // Keys mostly from a narrow pool so that hits, duplicates and erases are common
    function automatic skm_pkg::t_key pick_key(input int pool);
        case ($urandom_range(0, 9))
            0: return {$urandom()};
            1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return skm_pkg::t_key'($urandom_range(0, pool)) * 32'h0101_0101;
        endcase
    endfunction

    // Stimulus
    initial begin
        int            i;
        int            pool;
        int            burst;
        logic [2:0]    m;
        mismatch_count = 0;
        stimulus_done = 1'b0;

        // Directed: every mode, empty-map cases, key extremes, unused modes
        pending_requests.push_back(make_request(skm_pkg::MODE_FIND, 32'h0, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_READ, 32'h0, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_DELETE, 32'h0, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_ERASE, 32'h5, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_INSERT, 32'hFFFF_FFFF,
                                                32'hFFFF_FFFF, 8'hFF));
        pending_requests.push_back(make_request(skm_pkg::MODE_INSERT, 32'h0, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_INSERT, 32'h8000_0000,
                                                32'h1234_5678, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_INSERT, 32'h0, 32'hAAAA_AAAA,
                                                8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_FIND, 32'hFFFF_FFFF, 32'h0,
                                                8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_FIND, 32'h7FFF_FFFF, 32'h0,
                                                8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_READ, 32'h0, 32'h0, 8'd2));
        pending_requests.push_back(make_request(skm_pkg::MODE_READ, 32'h0, 32'h0, 8'd3));
        pending_requests.push_back(make_request(skm_pkg::MODE_READ, 32'h0, 32'h0, 8'hFF));
        pending_requests.push_back(make_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        pending_requests.push_back(make_request(3'd7, 32'h0, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_DELETE, 32'h0, 32'h0, 8'd1));
        pending_requests.push_back(make_request(skm_pkg::MODE_ERASE, 32'hFFFF_FFFF, 32'h0,
                                                8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_READ, 32'h0, 32'h0, 8'd0));
        pending_requests.push_back(make_request(skm_pkg::MODE_CLEAR, 32'h0, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_READ, 32'h0, 32'h0, 8'd0));

        // Fill the map completely, then prove full rejects and clear it
        for (i = 0; i < skm_pkg::Depth; i++)
            pending_requests.push_back(make_request(skm_pkg::MODE_INSERT,
                                                    {$urandom()} | 32'h1,
                                                    {$urandom()}, 8'($urandom())));
        pending_requests.push_back(make_request(skm_pkg::MODE_INSERT, 32'h0, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_READ, 32'h0, 32'h0, 8'hFF));
        pending_requests.push_back(make_request(skm_pkg::MODE_DELETE, 32'h0, 32'h0, 8'hFF));
        pending_requests.push_back(make_request(skm_pkg::MODE_DELETE, 32'h0, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_INSERT, 32'h0, 32'h0, 8'h0));
        for (i = 0; i < 40; i++)
            pending_requests.push_back(make_request(skm_pkg::MODE_READ, 32'h0, 32'h0,
                                                    8'($urandom())));
        pending_requests.push_back(make_request(skm_pkg::MODE_CLEAR, 32'h0, 32'h0, 8'h0));

        // Random bursts: insert-weighted mix of all modes, a burst sometimes ending in a clear
        while (pending_requests.size() < 1850) begin
            pool = $urandom_range(0, 1) ? 40 : 400;
            burst = $urandom_range(20, 120);
            for (i = 0; i < burst; i++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6: m = skm_pkg::MODE_INSERT;
                    7, 8, 9:             m = skm_pkg::MODE_ERASE;
                    10, 11, 12:          m = skm_pkg::MODE_FIND;
                    13, 14:              m = skm_pkg::MODE_DELETE;
                    15, 16, 17:          m = skm_pkg::MODE_READ;
                    18:                  m = 3'($urandom_range(6, 7));
                    default:             m = (i == burst - 1) ? skm_pkg::MODE_CLEAR
                                                              : skm_pkg::MODE_READ;
                endcase
                pending_requests.push_back(make_request(m, pick_key(pool), {$urandom()},
                    $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 60))));
            end
        end
        pending_requests.push_back(make_request(skm_pkg::MODE_CLEAR, 32'h0, 32'h0, 8'h0));
        pending_requests.push_back(make_request(skm_pkg::MODE_READ, 32'h0, 32'h0, 8'h0));
        stimulus_done = 1'b1;
    end

    // Reset and driver: one transaction per acceptance, random gaps between
    int send_gap;
    always @(posedge i_clk) begin
        if (cycle_count < 11) begin
            i_rst_n <= 1'b0;
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            i_rst_n <= 1'b1;
            if (i_valid && !o_stall) begin
                expected_answers.push_back(apply_map_op(pending_requests.pop_front()));
                if ($urandom_range(0, 3) == 0) send_gap <= 0;
                else send_gap <= $urandom_range(0, 6);
                if (pending_requests.size() > 0 && send_gap == 0 &&
                    $urandom_range(0, 1) == 0) begin
                    i_valid <= 1'b1;
                    {i_mode, i_key, i_value, i_position} <= pending_requests[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end else if (!i_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_requests.size() > 0) begin
                    i_valid <= 1'b1;
                    {i_mode, i_key, i_value, i_position} <= pending_requests[0];
                end
            end
        end
    end

    // Long receiver hold-off mid-run
    always @(posedge i_clk) begin
        if (cycle_count == 20000) long_hold <= 3000;
        else if (long_hold > 0) long_hold <= long_hold - 1;
    end

    // Receiver stall: random per transaction, plus the long hold-off
    int recv_gap;
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (long_hold > 1);
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", 32'h1, 32'h0);
            end else begin
                want = expected_answers.pop_front();
                if (o_ok !== want.ok) report_mismatch("ok", o_ok, want.ok);
                if (o_where !== want.where) report_mismatch("where", o_where, want.where);
                if (o_found_key !== want.found_key)
                    report_mismatch("found_key", o_found_key, want.found_key);
                if (o_found_value !== want.found_value)
                    report_mismatch("found_value", o_found_value, want.found_value);
                if (o_entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_entry_count, want.entry_count);
            end
        end
    end

    // Run control: drain, timeout
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_mode = skm_pkg::MODE_READ;
        i_key = '0;
        i_value = '0;
        i_position = '0;
        send_gap = 0;
        recv_gap = 0;
        while (!(stimulus_done && pending_requests.size() == 0 && !i_valid &&
                 expected_answers.size() == 0) && cycle_count < MaxCycles) begin
            @(posedge i_clk);
        end
        if (cycle_count >= MaxCycles) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            repeat (400) @(posedge i_clk);
            if (mismatch_count == 0 && expected_answers.size() == 0) begin
                $display("== PASS ==");
            end else begin
                $display("== FAIL ==");
            end
            $finish;
        end
    end

endmodule
